### rtl/ctb_pkg.sv
// Package for the color transform and blend unit: payload types, mode codes,
// register indexes and pipeline constants. Depends on nothing.
package ctb_pkg;

   localparam int NUM_STAGES = 13;
   localparam int DIV_STAGES = 8;
   localparam int CSR_ADDR_WIDTH = 5;

   localparam logic [7:0] MODE_MULTIPLY = 8'd3;
   localparam logic [7:0] MODE_ADD      = 8'd8;
   localparam logic [7:0] MODE_SUB_A    = 8'd9;
   localparam logic [7:0] MODE_SUB_B    = 8'd70;

   localparam logic [2:0] REG_ADD_RGBA   = 3'd0;
   localparam logic [2:0] REG_MULT_RED   = 3'd1;
   localparam logic [2:0] REG_MULT_GREEN = 3'd2;
   localparam logic [2:0] REG_MULT_BLUE  = 3'd3;
   localparam logic [2:0] REG_MULT_ALPHA = 3'd4;
   localparam logic [2:0] REG_BLEND_MODE = 3'd5;

   // floor(x / 255) == (x * RECIP_255) >> RECIP_SHIFT for every x below 2**18.
   localparam logic [18:0] RECIP_255   = 19'd263173;
   localparam int          RECIP_SHIFT = 26;

   typedef enum logic [1:0] {
      CLS_NORMAL,
      CLS_MULTIPLY,
      CLS_ADD,
      CLS_SUB
   } blend_class_type;

   typedef struct packed {
      logic [7:0] src_red;
      logic [7:0] src_green;
      logic [7:0] src_blue;
      logic [7:0] src_alpha;
      logic [7:0] dst_red;
      logic [7:0] dst_green;
      logic [7:0] dst_blue;
      logic [7:0] dst_alpha;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_payload_type;

   // Result that travels next to the divider: either the final pixel, or the
   // alpha of a normal blend whose colors still come out of the divider.
   typedef struct packed {
      logic            use_div;
      logic [3:0][7:0] pix;
   } side_type;

endpackage

### rtl/ctb_stream_if.sv
// Valid/ready stream interface used for both pixel channels.
// Depends on nothing; the payload type is given per instance.
interface ctb_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/ctb_xform.sv
// Color transform stages: Q8.8 multiply plus addend, then rounding and clamp.
// Depends on ctb_pkg.
module ctb_xform
   import ctb_pkg::*;
(
   input  logic                  clock,
   input  logic [1:0]            ld,
   input  req_payload_type       req,
   input  logic [31:0]           add_rgba,
   input  logic [3:0][15:0]      mult,
   output logic [3:0][7:0]       src_ff,
   output logic [3:0][7:0]       dst_ff
);

   logic [3:0][7:0]   src_raw;
   logic [3:0][7:0]   dst_raw;
   logic signed [24:0] v_in [4];
   logic signed [24:0] v_ff [4];
   logic [3:0][7:0]   dst0_ff;
   logic [3:0][7:0]   src_in;
   logic [24:0]       rnd [4];

   always_comb begin
      src_raw = {req.src_alpha, req.src_blue, req.src_green, req.src_red};
      dst_raw = {req.dst_alpha, req.dst_blue, req.dst_green, req.dst_red};
      for (int i = 0; i < 4; i++) begin
         v_in[i] = $signed({17'd0, src_raw[i]}) * $signed({{9{mult[i][15]}}, mult[i]})
                 + $signed({9'd0, add_rgba[8*(3-i) +: 8], 8'd0});
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         v_ff    <= v_in;
         dst0_ff <= dst_raw;
      end
   end

   // Negative sums round toward a value of zero or less and clamp to zero.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rnd[i] = {1'b0, v_ff[i][23:0]} + 25'd128;
         if (v_ff[i][24]) begin
            src_in[i] = 8'd0;
         end else if (|rnd[i][24:16]) begin
            src_in[i] = 8'd255;
         end else begin
            src_in[i] = rnd[i][15:8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         src_ff <= src_in;
         dst_ff <= dst0_ff;
      end
   end

endmodule

### rtl/ctb_prep.sv
// Blend preparation stages: mode products, blend weights, divide-by-255
// reciprocal products and the dividend and divisor for normal blending.
// Depends on ctb_pkg.
module ctb_prep
   import ctb_pkg::*;
(
   input  logic                  clock,
   input  logic [1:0]            ld,
   input  logic [3:0][7:0]       src,
   input  logic [3:0][7:0]       dst,
   input  logic [7:0]            blend_mode,
   output side_type              side,
   output logic [2:0][24:0]      dividend,
   output logic [16:0]           divisor
);

   blend_class_type   cls_in;
   blend_class_type   cls2_ff;
   blend_class_type   cls3_ff;
   logic [7:0]        fac;
   logic [15:0]       sp;
   logic [15:0]       d255;
   logic [2:0][16:0]  n_in;
   logic [2:0][16:0]  n_ff;
   logic [15:0]       sw_in;
   logic [15:0]       dw_in;
   logic [15:0]       sw_ff;
   logic [15:0]       dw_ff;
   logic [3:0][7:0]   src2_ff;
   logic [3:0][7:0]   dst2_ff;
   logic [2:0][23:0]  num_in;
   logic [2:0][23:0]  num_ff;
   logic [15:0]       den_in;
   logic [15:0]       den_ff;
   logic [17:0]       x;
   logic [36:0]       prod;
   logic [3:0][10:0]  qraw_in;
   logic [3:0][10:0]  qraw_ff;
   logic [3:0][7:0]   src3_ff;
   logic [3:0][7:0]   dst3_ff;
   logic [3:0][7:0]   q;

   always_comb begin
      unique case (blend_mode) inside
         MODE_MULTIPLY:          cls_in = CLS_MULTIPLY;
         MODE_ADD:               cls_in = CLS_ADD;
         MODE_SUB_A, MODE_SUB_B: cls_in = CLS_SUB;
         default:                cls_in = CLS_NORMAL;
      endcase
   end

   always_comb begin
      fac  = 8'd0;
      sp   = 16'd0;
      d255 = 16'd0;
      for (int i = 0; i < 3; i++) begin
         fac  = (cls_in == CLS_MULTIPLY) ? dst[i] : src[3];
         sp   = src[i] * fac;
         d255 = {dst[i], 8'd0} - {8'd0, dst[i]};
         case (cls_in)
            CLS_ADD: n_in[i] = {1'b0, d255} + {1'b0, sp};
            CLS_SUB: n_in[i] = (d255 > sp) ? {1'b0, d255 - sp} : 17'd0;
            default: n_in[i] = {1'b0, sp};
         endcase
      end
      sw_in = {src[3], 8'd0} - {8'd0, src[3]};
      dw_in = dst[3] * (8'd255 - src[3]);
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         cls2_ff <= cls_in;
         n_ff    <= n_in;
         sw_ff   <= sw_in;
         dw_ff   <= dw_in;
         src2_ff <= src;
         dst2_ff <= dst;
      end
   end

   // Lanes 0..2 divide the color terms by 255, lane 3 the blend weight sum.
   always_comb begin
      x    = 18'd0;
      prod = 37'd0;
      den_in = sw_ff + dw_ff;
      for (int i = 0; i < 3; i++) begin
         num_in[i] = ({16'd0, dst2_ff[i]} * {8'd0, dw_ff})
                   + ({16'd0, src2_ff[i]} * {8'd0, sw_ff});
      end
      for (int i = 0; i < 4; i++) begin
         x = (i == 3) ? ({2'd0, den_in} + 18'd127) : ({1'b0, n_ff[i % 3]} + 18'd127);
         prod = x * RECIP_255;
         qraw_in[i] = prod[36:RECIP_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         cls3_ff <= cls2_ff;
         num_ff  <= num_in;
         den_ff  <= den_in;
         qraw_ff <= qraw_in;
         src3_ff <= src2_ff;
         dst3_ff <= dst2_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         q[i] = (|qraw_ff[i][10:8]) ? 8'd255 : qraw_ff[i][7:0];
      end
      side.use_div = 1'b0;
      side.pix     = {dst3_ff[3], q[2], q[1], q[0]};
      if (cls3_ff == CLS_NORMAL) begin
         if (src3_ff[3] == 8'd0) begin
            side.pix = dst3_ff;
         end else if (src3_ff[3] == 8'd255) begin
            side.pix = src3_ff;
         end else begin
            side.use_div = 1'b1;
            side.pix     = {q[3], 24'd0};
         end
      end
      for (int i = 0; i < 3; i++) begin
         dividend[i] = {num_ff[i], 1'b0} + {9'd0, den_ff};
      end
      divisor = {den_ff, 1'b0};
   end

endmodule

### rtl/ctb_div.sv
// Restoring divider for normal blending, one quotient bit per pipeline stage,
// three color lanes sharing one divisor. Depends on ctb_pkg.
module ctb_div
   import ctb_pkg::*;
(
   input  logic                    clock,
   input  logic [DIV_STAGES-1:0]   ld,
   input  logic [2:0][24:0]        dividend,
   input  logic [16:0]             divisor,
   input  side_type                side_in,
   output logic [2:0][7:0]         quo,
   output side_type                side_out
);

   logic [2:0][24:0] rem_ff  [DIV_STAGES];
   logic [2:0][7:0]  quo_ff  [DIV_STAGES];
   logic [16:0]      dvs_ff  [DIV_STAGES];
   side_type         side_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [2:0][24:0] rem_src;
      logic [2:0][7:0]  quo_src;
      logic [16:0]      dvs_src;
      side_type         side_src;
      logic [24:0]      dsh;
      logic [25:0]      trial [3];
      logic [2:0][24:0] rem_in;
      logic [2:0][7:0]  quo_in;

      if (k == 0) begin : g_first
         assign rem_src  = dividend;
         assign quo_src  = '0;
         assign dvs_src  = divisor;
         assign side_src = side_in;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign quo_src  = quo_ff[k-1];
         assign dvs_src  = dvs_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      always_comb begin
         dsh = {8'd0, dvs_src} << (DIV_STAGES - 1 - k);
         for (int i = 0; i < 3; i++) begin
            trial[i]  = {1'b0, rem_src[i]} - {1'b0, dsh};
            rem_in[i] = trial[i][25] ? rem_src[i] : trial[i][24:0];
            quo_in[i] = {quo_src[i][6:0], ~trial[i][25]};
         end
      end

      always_ff @(posedge clock) begin
         if (ld[k]) begin
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            dvs_ff[k]  <= dvs_src;
            side_ff[k] <= side_src;
         end
      end
   end

   assign quo      = quo_ff[DIV_STAGES-1];
   assign side_out = side_ff[DIV_STAGES-1];

endmodule

### rtl/color_transform_blend_unit_core.sv
// Top level of the color transform and blend unit: register port, pipeline
// valid chain and output register. Depends on ctb_pkg, ctb_stream_if,
// ctb_xform, ctb_prep and ctb_div.
//
// Usage: each transfer on req_stream carries one source texel and one
// destination pixel; each transfer on rsp_stream carries exactly one blended
// pixel, in the order the inputs were taken. The source is color transformed
// (Q8.8 multiply, addend, rounding, clamp) and then blended by the mode in
// blend_mode. Registers must be written over the csr_ APB-style port only
// while no pixel is in flight; the block itself does not enforce this, and
// pready is always high. From an input transfer to its result on rsp_stream,
// a pixel passes two transform stages, two blend preparation stages, eight
// stages of the normal-blend divider (one quotient bit each) and the output
// register. Throughput is one pixel per cycle while rsp_stream takes results.
// Every stage has its own valid bit and loads when it is empty or when the
// stage after it moves, so a stalled receiver holds only the output and
// bubbles in the pipe still fill; req_stream.ready drops only when all
// stages hold pixels. Reset clears every valid bit and sets the registers
// to multipliers of 1.0, zero addends and normal blending.
module color_transform_blend_unit_core
   import ctb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   ctb_stream_if.sink                req_stream,
   ctb_stream_if.source              rsp_stream,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   logic [31:0]         add_rgba_ff;
   logic [3:0][15:0]    mult_ff;
   logic [7:0]          blend_mode_ff;
   logic                csr_write;
   logic [2:0]          csr_index;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES:0]   rdy;

   logic [3:0][7:0]     src_x;
   logic [3:0][7:0]     dst_x;
   side_type            side_p;
   logic [2:0][24:0]    dividend;
   logic [16:0]         divisor;
   logic [2:0][7:0]     quo;
   side_type            side_d;
   rsp_payload_type     out_in;
   rsp_payload_type     out_ff;

   // Register port. A write lands in the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         add_rgba_ff   <= 32'd0;
         mult_ff       <= {4{16'd256}};
         blend_mode_ff <= 8'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ADD_RGBA:   add_rgba_ff   <= csr_pwdata;
            REG_MULT_RED:   mult_ff[0]    <= csr_pwdata[15:0];
            REG_MULT_GREEN: mult_ff[1]    <= csr_pwdata[15:0];
            REG_MULT_BLUE:  mult_ff[2]    <= csr_pwdata[15:0];
            REG_MULT_ALPHA: mult_ff[3]    <= csr_pwdata[15:0];
            REG_BLEND_MODE: blend_mode_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ADD_RGBA:   csr_prdata = add_rgba_ff;
         REG_MULT_RED:   csr_prdata = {{16{mult_ff[0][15]}}, mult_ff[0]};
         REG_MULT_GREEN: csr_prdata = {{16{mult_ff[1][15]}}, mult_ff[1]};
         REG_MULT_BLUE:  csr_prdata = {{16{mult_ff[2][15]}}, mult_ff[2]};
         REG_MULT_ALPHA: csr_prdata = {{16{mult_ff[3][15]}}, mult_ff[3]};
         REG_BLEND_MODE: csr_prdata = {24'd0, blend_mode_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // A stage may load when it is empty or when its content moves on.
   always_comb begin
      rdy[NUM_STAGES] = rsp_stream.ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         rdy[k] = ~vld_ff[k] | rdy[k+1];
      end
      if (rdy[0]) begin
         vld_in[0] = req_stream.valid;
      end else begin
         vld_in[0] = vld_ff[0];
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (rdy[k]) begin
            vld_in[k] = vld_ff[k-1];
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stream.ready = rdy[0];

   ctb_xform u_xform (
      .clock    (clock),
      .ld       (rdy[1:0]),
      .req      (req_stream.payload),
      .add_rgba (add_rgba_ff),
      .mult     (mult_ff),
      .src_ff   (src_x),
      .dst_ff   (dst_x)
   );

   ctb_prep u_prep (
      .clock      (clock),
      .ld         (rdy[3:2]),
      .src        (src_x),
      .dst        (dst_x),
      .blend_mode (blend_mode_ff),
      .side       (side_p),
      .dividend   (dividend),
      .divisor    (divisor)
   );

   ctb_div u_div (
      .clock    (clock),
      .ld       (rdy[4 +: DIV_STAGES]),
      .dividend (dividend),
      .divisor  (divisor),
      .side_in  (side_p),
      .quo      (quo),
      .side_out (side_d)
   );

   // Only a partially transparent normal blend takes its colors from the
   // divider; every other case was settled before the divider.
   always_comb begin
      if (side_d.use_div) begin
         out_in = {quo[0], quo[1], quo[2], side_d.pix[3]};
      end else begin
         out_in = {side_d.pix[0], side_d.pix[1], side_d.pix[2], side_d.pix[3]};
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[NUM_STAGES-1]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_stream.valid   = vld_ff[NUM_STAGES-1];
   assign rsp_stream.payload = out_ff;

endmodule

### rtl/ctb_checker.sv
// Port-level checks for the color transform and blend unit, bound to the
// top level. Depends on ctb_pkg and color_transform_blend_unit_core.
module ctb_checker
   import ctb_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // A receiver that takes results never holds back the sender.
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output is drained");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("result changed before transfer");

endmodule

bind color_transform_blend_unit_core ctb_checker u_ctb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_stream.valid),
   .req_ready   (req_stream.ready),
   .rsp_valid   (rsp_stream.valid),
   .rsp_ready   (rsp_stream.ready),
   .rsp_payload (rsp_stream.payload)
);
